### rtl/hashed_strength_table_update_core_assert.svh
// Assertion macros for the hashed strength table core
`ifndef HASHED_STRENGTH_TABLE_UPDATE_CORE_ASSERT_SVH
`define HASHED_STRENGTH_TABLE_UPDATE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define HST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HST_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/hst_pkg.sv
package hst_pkg;
    localparam int unsigned CAPACITY = 256;
    localparam int unsigned PROBE_WINDOW = 8;
    localparam int unsigned SLOT_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned PRB_W = $clog2(PROBE_WINDOW + 1);
    localparam logic [15:0] ONE_Q15 = 16'd32768;
    localparam logic [15:0] LR_RESET = 16'd3277;

    localparam logic [1:0] CMD_OBSERVE = 2'd0;
    localparam logic [1:0] CMD_RESTORE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NOP = 2'd3;

    localparam logic [2:0] OUT_NEW = 3'd0;
    localparam logic [2:0] OUT_MATCH = 3'd1;
    localparam logic [2:0] OUT_EVICT = 3'd2;
    localparam logic [2:0] OUT_KEPT = 3'd3;
    localparam logic [2:0] OUT_SKIP = 3'd4;
    localparam logic [2:0] OUT_CLEAR = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_UPD_S,
        ST_UPD_M,
        ST_WRITE,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        HOP_MIX_A,
        HOP_MIX_B,
        HOP_FIN_A,
        HOP_FIN_B,
        HOP_FIN_C
    } hop_t;

    typedef struct packed {
        logic        load;
        logic [31:0] add_val;
        hop_t        op;
    } hash_ctl_t;
endpackage

### rtl/hst_hash_unit.sv
module hst_hash_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  hst_pkg::hash_ctl_t ctl,
    output logic [31:0]       hash
);
    import hst_pkg::*;

    logic [31:0] h_reg;
    logic [31:0] h_next;
    logic [31:0] base;

    always_comb
    begin
        base = ctl.load ? 32'd0 : h_reg;
        case (ctl.op)
            HOP_MIX_A: h_next = base + ctl.add_val;
            HOP_MIX_B: h_next = (h_reg + (h_reg << 10)) ^ ((h_reg + (h_reg << 10)) >> 6);
            HOP_FIN_A: h_next = h_reg + (h_reg << 3);
            HOP_FIN_B: h_next = h_reg ^ (h_reg >> 11);
            HOP_FIN_C: h_next = h_reg + (h_reg << 15);
            default:   h_next = h_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= '0;
        end
        else
        begin
            h_reg <= h_next;
        end
    end

    assign hash = h_reg;
endmodule

### rtl/hst_slot_store.sv
module hst_slot_store (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clr_all,
    input  logic [hst_pkg::SLOT_W-1:0] rd_addr,
    output logic                      rd_valid,
    output logic [87:0]               rd_key,
    output logic [15:0]               rd_strength,
    output logic [15:0]               rd_mean,
    input  logic                      wr_en,
    input  logic [hst_pkg::SLOT_W-1:0] wr_addr,
    input  logic [87:0]               wr_key,
    input  logic [15:0]               wr_strength,
    input  logic [15:0]               wr_mean,
    input  logic [15:0]               wr_age
);
    import hst_pkg::*;

    logic [CAPACITY-1:0] valid_reg;
    logic [87:0] key_mem [CAPACITY];
    logic [15:0] str_mem [CAPACITY];
    logic [15:0] mean_mem [CAPACITY];
    logic [15:0] age_mem [CAPACITY];
    logic rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (clr_all)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_key <= key_mem[rd_addr];
        rd_strength <= str_mem[rd_addr];
        rd_mean <= mean_mem[rd_addr];
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            str_mem[wr_addr] <= wr_strength;
            mean_mem[wr_addr] <= wr_mean;
            age_mem[wr_addr] <= wr_age;
        end
    end

    assign rd_valid = rd_valid_reg;
endmodule

### rtl/hashed_strength_table_update_core.sv
// Channel | Dir | Fields (low bit up)
// s_axis  | in  | tdata: cmd[1:0] act_code[33:2] sens_code[65:34]
//         |     |   context_byte[73:66] drive_chg[89:74] given_strength[105:90]
//         |     |   given_age[121:106], zero to bit 127
// m_axis  | out | tdata: slot_index[7:0] outcome[10:8] entry_strength[26:11]
//         |     |   entry_count[35:27], zero to bit 39
// cfg     | in  | learn_rate, written when cfg_we is high
// An item is hashed in ST_HASH, its start slot loaded in ST_CLEAR, and each probed slot read
// and checked in ST_PROBE_RD/ST_PROBE_CHK; then ST_UPD_S, ST_UPD_M and ST_WRITE run as needed
// and ST_DONE posts it. Clear, the unused command and a zero-key restore skip to ST_DONE.
// Reset clears the valid bits at once; no clearing pass is needed.
// s_axis_tready is high only in idle; a result not yet taken holds the next item in ST_DONE.
module hashed_strength_table_update_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // cmd, act_code, sens_code, context_byte,
                                        // drive_chg, given_strength, given_age
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata   // slot_index, outcome, entry_strength, entry_count
);
    import hst_pkg::*;

    `include "hashed_strength_table_update_core_assert.svh"

    state_t state_reg, state_next;
    logic [15:0] lr_reg;
    logic [121:0] in_reg;
    logic [3:0] hstep_reg, hstep_next;
    logic [PRB_W-1:0] probe_reg, probe_next;
    logic [SLOT_W-1:0] start_reg, start_next;
    logic [SLOT_W-1:0] weak_reg, weak_next;
    logic [16:0] weak_str_reg, weak_str_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [2:0] outcome_reg, outcome_next;
    logic [15:0] str_reg, str_next;
    logic [15:0] mean_reg, mean_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0] prod_reg, prod_next;
    logic [39:0] out_reg, out_next;
    logic out_valid_reg, out_valid_next;
    logic [15:0] old_str_reg, old_str_next;
    logic [15:0] old_mean_reg, old_mean_next;

    logic [1:0] f_cmd;
    logic [31:0] f_a, f_s;
    logic [7:0] f_c;
    logic [15:0] f_d, f_gs, f_ga, gs_sat, lr_eff;
    logic [87:0] key;
    hash_ctl_t hctl;
    logic [31:0] hash;
    logic clr_all, wr_en;
    logic [SLOT_W-1:0] rd_addr;
    logic rd_valid;
    logic [87:0] rd_key;
    logic [15:0] rd_strength, rd_mean;
    logic [15:0] wr_strength, wr_mean, wr_age;
    logic [SLOT_W-1:0] probe_slot;

    logic signed [16:0] diff;
    logic signed [33:0] sprod;
    logic signed [33:0] squot;
    logic signed [17:0] msum;

    assign f_cmd = in_reg[1:0];
    assign f_a = in_reg[33:2];
    assign f_s = in_reg[65:34];
    assign f_c = in_reg[73:66];
    assign f_d = in_reg[89:74];
    assign f_gs = in_reg[105:90];
    assign f_ga = in_reg[121:106];
    assign gs_sat = (f_gs > ONE_Q15) ? ONE_Q15 : f_gs;
    assign lr_eff = (lr_reg > ONE_Q15) ? ONE_Q15 : lr_reg;
    assign key = {f_c, f_s, f_a};
    assign probe_slot = start_reg + SLOT_W'(probe_reg);

    hst_hash_unit u_hash (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (hctl),
        .hash (hash)
    );

    hst_slot_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .clr_all    (clr_all),
        .rd_addr    (rd_addr),
        .rd_valid   (rd_valid),
        .rd_key     (rd_key),
        .rd_strength(rd_strength),
        .rd_mean    (rd_mean),
        .wr_en      (wr_en),
        .wr_addr    (slot_reg),
        .wr_key     (key),
        .wr_strength(wr_strength),
        .wr_mean    (wr_mean),
        .wr_age     (wr_age)
    );

    assign wr_strength = str_reg;
    assign wr_mean = mean_reg;
    assign wr_age = (f_cmd == CMD_RESTORE) ? f_ga : 16'd0;
    assign rd_addr = probe_slot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lr_reg <= LR_RESET;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
            hstep_reg <= '0;
            probe_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
            hstep_reg <= hstep_next;
            probe_reg <= probe_next;
            if (cfg_we)
            begin
                lr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_reg <= s_axis_tdata[121:0];
        end
        start_reg <= start_next;
        weak_reg <= weak_next;
        weak_str_reg <= weak_str_next;
        slot_reg <= slot_next;
        outcome_reg <= outcome_next;
        str_reg <= str_next;
        mean_reg <= mean_next;
        prod_reg <= prod_next;
        out_reg <= out_next;
        old_str_reg <= old_str_next;
        old_mean_reg <= old_mean_next;
    end

    always_comb
    begin
        state_next = state_reg;
        hstep_next = hstep_reg;
        probe_next = probe_reg;
        start_next = start_reg;
        weak_next = weak_reg;
        weak_str_next = weak_str_reg;
        slot_next = slot_reg;
        outcome_next = outcome_reg;
        str_next = str_reg;
        mean_next = mean_reg;
        count_next = count_reg;
        prod_next = prod_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        old_str_next = old_str_reg;
        old_mean_next = old_mean_reg;
        hctl.load = 1'b0;
        hctl.add_val = 32'd0;
        hctl.op = HOP_FIN_B;
        clr_all = 1'b0;
        wr_en = 1'b0;
        s_axis_tready = 1'b0;
        diff = 17'sd0;
        sprod = 34'sd0;
        squot = 34'sd0;
        msum = 18'sd0;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = ST_HASH;
                    hstep_next = '0;
                end
            end
            ST_HASH:
            begin
                if (hstep_reg == 4'd0 && (f_cmd == CMD_CLEAR || f_cmd == CMD_NOP ||
                    (f_cmd == CMD_RESTORE && f_a == 32'd0 && f_s == 32'd0)))
                begin
                    clr_all = (f_cmd == CMD_CLEAR);
                    if (f_cmd == CMD_CLEAR)
                    begin
                        count_next = '0;
                        outcome_next = OUT_CLEAR;
                    end
                    else
                    begin
                        outcome_next = OUT_SKIP;
                    end
                    slot_next = '0;
                    str_next = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    hstep_next = hstep_reg + 4'd1;
                    unique case (hstep_reg)
                        4'd0: begin hctl.load = 1'b1; hctl.op = HOP_MIX_A; hctl.add_val = f_a; end
                        4'd1: hctl.op = HOP_MIX_B;
                        4'd2: begin hctl.op = HOP_MIX_A; hctl.add_val = f_s; end
                        4'd3: hctl.op = HOP_MIX_B;
                        4'd4: begin hctl.op = HOP_MIX_A; hctl.add_val = {24'd0, f_c}; end
                        4'd5: hctl.op = HOP_MIX_B;
                        4'd6: hctl.op = HOP_FIN_A;
                        4'd7: hctl.op = HOP_FIN_B;
                        4'd8:
                        begin
                            hctl.op = HOP_FIN_C;
                            state_next = ST_CLEAR;
                        end
                        default: hctl.op = HOP_FIN_B;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                start_next = hash[SLOT_W-1:0];
                weak_next = hash[SLOT_W-1:0];
                weak_str_next = 17'h10000;
                probe_next = '0;
                state_next = ST_PROBE_RD;
            end
            ST_PROBE_RD:
            begin
                state_next = ST_PROBE_CHK;
            end
            ST_PROBE_CHK:
            begin
                slot_next = probe_slot;
                old_str_next = rd_strength;
                old_mean_next = rd_mean;
                if (!rd_valid)
                begin
                    outcome_next = OUT_NEW;
                    count_next = count_reg + CNT_W'(1);
                    str_next = (f_cmd == CMD_OBSERVE) ? lr_eff : gs_sat;
                    mean_next = f_d;
                    state_next = ST_WRITE;
                end
                else if (rd_key == key)
                begin
                    if (f_cmd == CMD_OBSERVE)
                    begin
                        outcome_next = OUT_MATCH;
                        prod_next = 32'(lr_eff) * 32'(ONE_Q15 - rd_strength);
                        state_next = ST_UPD_S;
                    end
                    else if (gs_sat > rd_strength)
                    begin
                        outcome_next = OUT_MATCH;
                        str_next = gs_sat;
                        mean_next = f_d;
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        outcome_next = OUT_KEPT;
                        str_next = rd_strength;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    if ({1'b0, rd_strength} < weak_str_reg)
                    begin
                        weak_str_next = {1'b0, rd_strength};
                        weak_next = probe_slot;
                    end
                    if (probe_reg == PRB_W'(PROBE_WINDOW - 1))
                    begin
                        slot_next = ({1'b0, rd_strength} < weak_str_reg) ? probe_slot : weak_reg;
                        outcome_next = OUT_EVICT;
                        str_next = (f_cmd == CMD_OBSERVE) ? lr_eff : gs_sat;
                        mean_next = f_d;
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        probe_next = probe_reg + PRB_W'(1);
                        state_next = ST_PROBE_RD;
                    end
                end
            end
            ST_UPD_S:
            begin
                str_next = old_str_reg + prod_reg[30:15];
                diff = $signed({f_d[15], f_d}) - $signed({old_mean_reg[15], old_mean_reg});
                prod_next = $signed({16'd0, lr_eff}) * $signed({{15{diff[16]}}, diff});
                state_next = ST_UPD_M;
            end
            ST_UPD_M:
            begin
                sprod = 34'($signed(prod_reg));
                squot = (sprod < 0) ? -((-sprod) >>> 15) : (sprod >>> 15);
                msum = 18'($signed({{2{old_mean_reg[15]}}, old_mean_reg})) + squot[17:0];
                if (msum > 18'sd32767)
                begin
                    mean_next = 16'h7FFF;
                end
                else if (msum < -18'sd32768)
                begin
                    mean_next = 16'h8000;
                end
                else
                begin
                    mean_next = msum[15:0];
                end
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                wr_en = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_next = {4'd0, count_reg[8:0], str_reg, outcome_reg, slot_reg[7:0]};
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_reg;

    `HST_ASSERT_IMP(a_ready_idle, clk, rst_n, s_axis_tready, state_reg == ST_IDLE)
    `HST_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `HST_ASSERT_NXT(a_write_done, clk, rst_n, wr_en, state_reg == ST_DONE)
    `HST_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, !s_axis_tready)
endmodule
